### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

### hw/rtl/i2cee_pkg.sv
// Types and constants of the I2C EEPROM byte master.
`timescale 1ns / 1ps
package i2cee_pkg;

	localparam logic [1:0] FUNC_TICK  = 2'd0;
	localparam logic [1:0] FUNC_WRITE = 2'd1;
	localparam logic [1:0] FUNC_READ  = 2'd2;

	localparam logic [1:0] CFG_DEV_SEL    = 2'd0;
	localparam logic [1:0] CFG_PHASE_TICKS = 2'd1;
	localparam logic [1:0] CFG_ACK_TIMEOUT = 2'd2;

	localparam logic [6:0] DEV_SEL_RST     = 7'd80;
	localparam logic [7:0] PHASE_TICKS_RST = 8'd1;
	localparam logic [7:0] ACK_TIMEOUT_RST = 8'd200;

	localparam logic [1:0] BYTE_SEL  = 2'd0;
	localparam logic [1:0] BYTE_ADDR = 2'd1;
	localparam logic [1:0] BYTE_LAST = 2'd2;

	localparam logic [3:0] BITS_PER_BYTE = 4'd8;

	typedef enum logic [20:0] {
		PH_IDLE    = 21'h000001,
		PH_ST_A    = 21'h000002,
		PH_RS_A    = 21'h000004,
		PH_ST_B    = 21'h000008,
		PH_ST_C    = 21'h000010,
		PH_ST_D    = 21'h000020,
		PH_TX_A    = 21'h000040,
		PH_TX_B    = 21'h000080,
		PH_TX_C    = 21'h000100,
		PH_AK_A    = 21'h000200,
		PH_AK_B    = 21'h000400,
		PH_AK_POLL = 21'h000800,
		PH_AK_END  = 21'h001000,
		PH_RX_A    = 21'h002000,
		PH_RX_B    = 21'h004000,
		PH_RX_C    = 21'h008000,
		PH_NK_A    = 21'h010000,
		PH_NK_B    = 21'h020000,
		PH_SP_A    = 21'h040000,
		PH_SP_B    = 21'h080000,
		PH_SP_C    = 21'h100000
	} phase_t;

	typedef struct packed {
		logic [6:0] dev_sel;
		logic [7:0] phase_ticks;
		logic [7:0] ack_timeout;
	} cfg_t;

	typedef struct packed {
		logic       scl;
		logic       sda;
		logic       busy;
		logic       done;
		logic [7:0] read_data;
		logic       ack_failed;
	} result_t;

endpackage

### hw/rtl/i2cee_cmd_if.sv
// Command channel: one bus tick with optional command.
`timescale 1ns / 1ps
interface i2cee_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] func;
	logic [7:0] mem_addr;
	logic [7:0] write_data;
	logic       sda_in;

	modport source (output valid, func, mem_addr, write_data, sda_in, input ready);
	modport sink (input valid, func, mem_addr, write_data, sda_in, output ready);
endinterface

### hw/rtl/i2cee_res_if.sv
// Result channel: bus levels and status for one tick.
`timescale 1ns / 1ps
interface i2cee_res_if;
	logic       valid;
	logic       ready;
	logic       scl_out;
	logic       sda_out;
	logic       busy_res;
	logic       done_res;
	logic [7:0] read_data;
	logic       ack_failed;

	modport source (output valid, scl_out, sda_out, busy_res, done_res, read_data,
		ack_failed, input ready);
	modport sink (input valid, scl_out, sda_out, busy_res, done_res, read_data,
		ack_failed, output ready);
endinterface

### hw/rtl/i2cee_seq.sv
// Bus sequencer: transaction state and per-tick bus levels.
`timescale 1ns / 1ps
module i2cee_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [1:0]          func,
	input  logic [7:0]          mem_addr,
	input  logic [7:0]          write_data,
	input  logic                sda_in,
	input  i2cee_pkg::cfg_t     cfg,
	output i2cee_pkg::result_t  result
);
	import i2cee_pkg::*;

	phase_t     phase_q, cur_phase, n_phase;
	logic [3:0] bit_q, cur_bit, n_bit, bit_inc;
	logic [7:0] shift_q, n_shift;
	logic [7:0] tick_q, cur_tick, n_tick;
	logic [7:0] wait_q, n_wait;
	logic       is_read_q, cur_is_read;
	logic [7:0] addr_q, cur_addr;
	logic [7:0] data_q, cur_data;
	logic       err_q, cur_err, n_err;
	logic [1:0] bidx_q, cur_bidx, n_bidx;
	logic [7:0] rbyte_q, n_rbyte;
	logic       start, phase_end, done, scl, sdo;
	logic [7:0] pt;

	assign start = (phase_q == PH_IDLE) && (func == FUNC_WRITE || func == FUNC_READ);
	assign cur_phase   = start ? PH_ST_A : phase_q;
	assign cur_is_read = start ? (func == FUNC_READ) : is_read_q;
	assign cur_addr    = start ? mem_addr : addr_q;
	assign cur_data    = start ? write_data : data_q;
	assign cur_err     = start ? 1'b0 : err_q;
	assign cur_bidx    = start ? BYTE_SEL : bidx_q;
	assign cur_bit     = start ? 4'd0 : bit_q;
	assign cur_tick    = start ? 8'd0 : tick_q;
	assign bit_inc     = cur_bit + 4'd1;

	assign pt = (cfg.phase_ticks == 8'd0) ? 8'd1 : cfg.phase_ticks;
	assign phase_end = ({1'b0, cur_tick} + 9'd1) >= {1'b0, pt};

	always_comb begin
		scl = 1'b1;
		sdo = 1'b1;
		case (cur_phase)
			PH_RS_A: begin scl = 1'b0; sdo = 1'b1; end
			PH_ST_C: begin scl = 1'b1; sdo = 1'b0; end
			PH_ST_D: begin scl = 1'b0; sdo = 1'b0; end
			PH_TX_A: begin scl = 1'b0; sdo = shift_q[7]; end
			PH_TX_B: begin scl = 1'b1; sdo = shift_q[7]; end
			PH_TX_C: begin scl = 1'b0; sdo = shift_q[7]; end
			PH_AK_A, PH_AK_END, PH_RX_C, PH_NK_B: begin scl = 1'b0; sdo = 1'b1; end
			PH_SP_A: begin scl = 1'b0; sdo = 1'b0; end
			PH_SP_B: begin scl = 1'b1; sdo = 1'b0; end
			default: begin scl = 1'b1; sdo = 1'b1; end
		endcase
	end

	always_comb begin
		n_phase = cur_phase;
		n_bit   = cur_bit;
		n_shift = shift_q;
		n_tick  = cur_tick;
		n_wait  = wait_q;
		n_err   = cur_err;
		n_bidx  = cur_bidx;
		n_rbyte = rbyte_q;
		done    = 1'b0;
		if (cur_phase == PH_AK_POLL) begin
			n_tick = 8'd0;
			if (!sda_in) begin
				n_phase = PH_AK_END;
			end else if (wait_q >= cfg.ack_timeout) begin
				n_err   = 1'b1;
				n_phase = PH_AK_END;
			end else begin
				n_wait = wait_q + 8'd1;
			end
		end else if (cur_phase != PH_IDLE) begin
			if (phase_end) begin
				n_tick = 8'd0;
				case (cur_phase)
					PH_ST_A, PH_RS_A: n_phase = PH_ST_B;
					PH_ST_B: n_phase = PH_ST_C;
					PH_ST_C: n_phase = PH_ST_D;
					PH_ST_D: begin
						n_shift = {cfg.dev_sel, cur_bidx == BYTE_LAST};
						n_bit   = 4'd0;
						n_phase = PH_TX_A;
					end
					PH_TX_A: n_phase = PH_TX_B;
					PH_TX_B: n_phase = PH_TX_C;
					PH_TX_C: begin
						n_shift = {shift_q[6:0], 1'b0};
						n_bit   = bit_inc;
						n_phase = (bit_inc >= BITS_PER_BYTE) ? PH_AK_A : PH_TX_A;
					end
					PH_AK_A: n_phase = PH_AK_B;
					PH_AK_B: begin
						n_wait  = 8'd0;
						n_phase = PH_AK_POLL;
					end
					PH_AK_END: begin
						if (cur_bidx == BYTE_SEL) begin
							n_bidx  = BYTE_ADDR;
							n_shift = cur_addr;
							n_bit   = 4'd0;
							n_phase = PH_TX_A;
						end else if (cur_bidx == BYTE_ADDR) begin
							n_bidx = BYTE_LAST;
							if (cur_is_read) begin
								n_phase = PH_RS_A;
							end else begin
								n_shift = cur_data;
								n_bit   = 4'd0;
								n_phase = PH_TX_A;
							end
						end else if (cur_is_read) begin
							n_shift = 8'd0;
							n_bit   = 4'd0;
							n_phase = PH_RX_A;
						end else begin
							n_phase = PH_SP_A;
						end
					end
					PH_RX_A: begin
						n_shift = {shift_q[6:0], sda_in};
						n_phase = PH_RX_B;
					end
					PH_RX_B: n_phase = PH_RX_C;
					PH_RX_C: begin
						n_bit = bit_inc;
						if (bit_inc >= BITS_PER_BYTE) begin
							n_rbyte = shift_q;
							n_phase = PH_NK_A;
						end else begin
							n_phase = PH_RX_A;
						end
					end
					PH_NK_A: n_phase = PH_NK_B;
					PH_NK_B: n_phase = PH_SP_A;
					PH_SP_A: n_phase = PH_SP_B;
					PH_SP_B: n_phase = PH_SP_C;
					PH_SP_C: begin
						done    = 1'b1;
						n_phase = PH_IDLE;
					end
					default: n_phase = PH_IDLE;
				endcase
			end else begin
				n_tick = cur_tick + 8'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			bit_q     <= 4'd0;
			shift_q   <= 8'd0;
			tick_q    <= 8'd0;
			wait_q    <= 8'd0;
			is_read_q <= 1'b0;
			addr_q    <= 8'd0;
			data_q    <= 8'd0;
			err_q     <= 1'b0;
			bidx_q    <= BYTE_SEL;
			rbyte_q   <= 8'd0;
		end else if (step) begin
			phase_q   <= n_phase;
			bit_q     <= n_bit;
			shift_q   <= n_shift;
			tick_q    <= n_tick;
			wait_q    <= n_wait;
			is_read_q <= cur_is_read;
			addr_q    <= cur_addr;
			data_q    <= cur_data;
			err_q     <= n_err;
			bidx_q    <= n_bidx;
			rbyte_q   <= n_rbyte;
		end
	end

	assign result.scl        = scl;
	assign result.sda        = sdo;
	assign result.busy       = (cur_phase != PH_IDLE);
	assign result.done       = done;
	assign result.read_data  = n_rbyte;
	assign result.ack_failed = n_err;

endmodule

### hw/rtl/i2c_eeprom_byte_master.sv
// Top level of the I2C EEPROM byte master.
//
// Each command word is one bus tick; the block takes one word per clock and returns one
// result word per word in the next cycle through an output register. Words keep flowing
// back to back while the result side takes them; a stalled result holds the input off
// until taken. While idle, func starts a byte write or a random read; during a transaction
// func is ignored. Every SCL/SDA phase lasts phase_ticks words (0 acts as 1), an
// acknowledge poll takes one word per sample and fails after ack_timeout + 1 high samples,
// which sets the sticky ack_failed flag without stopping the transaction. The user writes
// configuration via cfg_we / cfg_idx / cfg_wdata while the block is idle; not enforced.
`timescale 1ns / 1ps
module i2c_eeprom_byte_master (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_idx,
	input  logic [7:0] cfg_wdata,
	i2cee_cmd_if.sink  cmd,
	i2cee_res_if.source res
);
	import i2cee_pkg::*;
	`include "assert_macros.svh"

	cfg_t    cfg_q;
	result_t result;
	result_t res_q;
	logic    out_v_q;
	logic    step;

	assign cmd.ready = !out_v_q || res.ready;
	assign step      = cmd.valid && cmd.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dev_sel     <= DEV_SEL_RST;
			cfg_q.phase_ticks <= PHASE_TICKS_RST;
			cfg_q.ack_timeout <= ACK_TIMEOUT_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_DEV_SEL:     cfg_q.dev_sel     <= cfg_wdata[6:0];
				CFG_PHASE_TICKS: cfg_q.phase_ticks <= cfg_wdata;
				CFG_ACK_TIMEOUT: cfg_q.ack_timeout <= cfg_wdata;
				default: ;
			endcase
		end
	end

	i2cee_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.func       (cmd.func),
		.mem_addr   (cmd.mem_addr),
		.write_data (cmd.write_data),
		.sda_in     (cmd.sda_in),
		.cfg        (cfg_q),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (cmd.ready) begin
			out_v_q <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= result;
		end
	end

	assign res.valid      = out_v_q;
	assign res.scl_out    = res_q.scl;
	assign res.sda_out    = res_q.sda;
	assign res.busy_res   = res_q.busy;
	assign res.done_res   = res_q.done;
	assign res.read_data  = res_q.read_data;
	assign res.ack_failed = res_q.ack_failed;

	`ASSERT_IMPLY(a_done_in_stop, clk, arst_n, out_v_q && res_q.done, res_q.busy && res_q.scl && res_q.sda, "done outside stop")
	`ASSERT_IMPLY(a_idle_released, clk, arst_n, out_v_q && !res_q.busy, res_q.scl && res_q.sda && !res_q.done, "bus driven while idle")
	`ASSERT_NEXT(a_word_lands, clk, arst_n, step, out_v_q, "accepted word lost")

endmodule
